// ----- design/sac_pkg.sv -----
// Shared types and constants for the set-associative LRU tag store.
// No dependencies; imported by every module of the block except sac_tag_ram.
package sac_pkg;

  localparam int ADDR_W     = 32;  // access address
  localparam int TAG_W      = 32;  // stored tag
  localparam int CNT_W      = 32;  // hit / miss totals
  localparam int WAY_OUT_W  = 3;   // way field of a result
  localparam int CFG_W      = 4;   // each config register
  localparam int RAW_IDX_W  = 15;  // masked set index, index_bits tops out at 15
  localparam int NWAY_W     = 5;   // holds an effective way count up to 16
  localparam int APB_ADDR_W = 4;   // three registers at 0x0, 0x4, 0x8
  localparam int APB_DATA_W = 32;

  localparam int DEF_MAX_SETS    = 1024;
  localparam int DEF_MAX_WAYS    = 8;
  localparam int DEF_STAMP_WIDTH = 32;

  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd6;
  localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 4'd4;
  localparam logic [CFG_W-1:0] RST_WAYS_IN_USE = 4'd1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_LOOKUP
  } state_t;

endpackage

// ----- design/set_assoc_cache_lru_lookup_top.sv -----
// Set-associative tag store with true LRU (timestamp) replacement.
// An accepted address gets its set index (via S_INDEX if MAX_SETS is not a power of two),
// its set row is read, and the result word is registered in S_LOOKUP. One address at a
// time, bound by the set row read-modify-write: the next read waits for the write-back,
// which waits while out_stall holds the result. Reset: synchronous; after rst a clearing
// pass zeroes all rows with in_stall high throughout. Config writes are taken at any time.
module set_assoc_cache_lru_lookup_top #(
  parameter int MAX_SETS    = sac_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS    = sac_pkg::DEF_MAX_WAYS,
  parameter int STAMP_WIDTH = sac_pkg::DEF_STAMP_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // address channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sac_pkg::ADDR_W-1:0]       address,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic [sac_pkg::WAY_OUT_W-1:0]    way,
  output logic [sac_pkg::CNT_W-1:0]        hit_count,
  output logic [sac_pkg::CNT_W-1:0]        miss_count,
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sac_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sac_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sac_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import sac_pkg::*;

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W = 1 + TAG_W + STAMP_WIDTH;  // {valid, tag, stamp}
  localparam int ROW_W  = MAX_WAYS * LINE_W;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] offset_bits;
  logic [CFG_W-1:0] index_bits;
  logic [CFG_W-1:0] ways_in_use;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= RST_OFFSET_BITS;
      index_bits  <= RST_INDEX_BITS;
      ways_in_use <= RST_WAYS_IN_USE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_OFFSET_BITS: offset_bits <= pwdata[CFG_W-1:0];
        REG_INDEX_BITS:  index_bits  <= pwdata[CFG_W-1:0];
        REG_WAYS_IN_USE: ways_in_use <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OFFSET_BITS: prdata = APB_DATA_W'(offset_bits);
      REG_INDEX_BITS:  prdata = APB_DATA_W'(index_bits);
      REG_WAYS_IN_USE: prdata = APB_DATA_W'(ways_in_use);
      default:         prdata = '0;
    endcase
  end

  // Effective associativity: 0 acts as 1, clamp at MAX_WAYS.
  logic [NWAY_W-1:0]   nways;
  logic [MAX_WAYS-1:0] way_en;

  always_comb begin
    if (ways_in_use == '0) begin
      nways = NWAY_W'(1);
    end else if (NWAY_W'(ways_in_use) > NWAY_W'(MAX_WAYS)) begin
      nways = NWAY_W'(MAX_WAYS);
    end else begin
      nways = NWAY_W'(ways_in_use);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en[w] = NWAY_W'(w) < nways;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_t           state;
  state_t           state_next;
  logic [SET_W-1:0] clear_ptr;
  logic             accept;
  logic             idx_done;
  logic [SET_W-1:0] idx_set;
  logic             rd_en;
  logic             slot_free;   // result register can take a new word
  logic             lookup_done;
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clear_ptr == LAST_SET) state_next = S_IDLE;
      S_IDLE:   if (accept) state_next = idx_done ? S_LOOKUP : S_INDEX;
      S_INDEX:  if (idx_done) state_next = S_LOOKUP;
      S_LOOKUP: if (slot_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    rd_en       = 1'b0;
    lookup_done = 1'b0;
    case (state)
      S_CLEAR: ;
      S_IDLE: begin
        in_stall = 1'b0;
        rd_en    = accept && idx_done;
      end
      S_INDEX:  rd_en       = idx_done;
      S_LOOKUP: lookup_done = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_ptr <= '0;
    end else if (state == S_CLEAR) begin
      clear_ptr <= clear_ptr + SET_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Address split
  // ---------------------------------------------------------------------------
  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] set_q;

  sac_index #(
    .MAX_SETS (MAX_SETS),
    .SET_W    (SET_W)
  ) u_index (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .address     (address),
    .offset_bits (offset_bits),
    .index_bits  (index_bits),
    .done        (idx_done),
    .set_idx     (idx_set)
  );

  // shift never exceeds 30, so the tag is a plain right shift
  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q <= TAG_W'(address >> ({1'b0, offset_bits} + {1'b0, index_bits}));
    end
    if (rd_en) begin
      set_q <= idx_set;
    end
  end

  // ---------------------------------------------------------------------------
  // Tag memory and way logic
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]       row;
  logic [ROW_W-1:0]       row_new;
  logic                   sel_hit;
  logic [WAY_W-1:0]       sel_way;
  logic [STAMP_WIDTH-1:0] stamp;
  logic [STAMP_WIDTH-1:0] stamp_next;

  // clearing pass owns the write port until it is done
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clear_ptr;
      ram_wdata = '0;
    end else begin
      ram_we    = lookup_done;
      ram_waddr = set_q;
      ram_wdata = row_new;
    end
  end

  sac_tag_ram #(
    .DEPTH (MAX_SETS),
    .WIDTH (ROW_W),
    .AW    (SET_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (idx_set),
    .rdata (row)
  );

  // stamp counter saturates instead of wrapping
  assign stamp_next = (stamp == {STAMP_WIDTH{1'b1}}) ? stamp : stamp + STAMP_WIDTH'(1);

  sac_way_sel #(
    .MAX_WAYS (MAX_WAYS),
    .STAMP_W  (STAMP_WIDTH),
    .WAY_W    (WAY_W),
    .LINE_W   (LINE_W)
  ) u_way_sel (
    .row     (row),
    .tag     (tag_q),
    .way_en  (way_en),
    .stamp   (stamp_next),
    .hit     (sel_hit),
    .way     (sel_way),
    .row_new (row_new)
  );

  // ---------------------------------------------------------------------------
  // Totals and result word. The totals registers double as the count fields:
  // they only move when a new word is loaded.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] hits_total;
  logic [CNT_W-1:0] misses_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp        <= '0;
      hits_total   <= '0;
      misses_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (lookup_done) begin
        stamp     <= stamp_next;
        out_valid <= 1'b1;
        if (sel_hit) begin
          if (hits_total != {CNT_W{1'b1}}) hits_total <= hits_total + CNT_W'(1);
        end else begin
          if (misses_total != {CNT_W{1'b1}}) misses_total <= misses_total + CNT_W'(1);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_done) begin
      hit <= sel_hit;
      way <= WAY_OUT_W'(sel_way);
    end
  end

  assign hit_count  = hits_total;
  assign miss_count = misses_total;

endmodule

// ----- design/sac_index.sv -----
// Set index unit: address -> set number, reduced modulo the number of rows.
// Depends on sac_pkg. Same-cycle for power-of-two row counts, else ready in the cycle after start.
module sac_index #(
  parameter int MAX_SETS = sac_pkg::DEF_MAX_SETS,
  parameter int SET_W    = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sac_pkg::ADDR_W-1:0]  address,
  input  logic [sac_pkg::CFG_W-1:0]   offset_bits,
  input  logic [sac_pkg::CFG_W-1:0]   index_bits,
  output logic                        done,
  output logic [SET_W-1:0]            set_idx
);
  import sac_pkg::*;

  localparam bit IS_POW2 = (MAX_SETS & (MAX_SETS - 1)) == 0;

  logic [ADDR_W-1:0]    shifted;
  logic [ADDR_W-1:0]    idx_mask;
  logic [ADDR_W-1:0]    raw32;

  assign shifted  = address >> offset_bits;
  assign idx_mask = (ADDR_W'(1) << index_bits) - ADDR_W'(1);
  assign raw32    = shifted & idx_mask;

  if (IS_POW2) begin : g_pow2
    assign done    = start;
    assign set_idx = SET_W'(raw32 & ADDR_W'(MAX_SETS - 1));
  end else begin : g_recip
    // raw % M via q = (raw * floor(2^32/M)) >> 32, low by at most one
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MAX_SETS);
    localparam logic [31:0] MODV  = 32'(MAX_SETS);

    logic                 busy;
    logic [RAW_IDX_W-1:0] raw;
    logic [RAW_IDX_W-1:0] raw_q;
    logic [47:0]          prod_q;
    logic [15:0]          quot;
    logic [31:0]          qm;
    logic [31:0]          rem;
    logic [31:0]          rem_fix;

    assign raw = raw32[RAW_IDX_W-1:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        busy <= 1'b0;
      end else begin
        busy <= start;
      end
    end

    always_ff @(posedge clk) begin
      raw_q  <= raw;
      prod_q <= 48'(raw) * 48'(RECIP);
    end

    assign quot    = prod_q[47:32];
    assign qm      = 32'(quot) * MODV;
    assign rem     = 32'(raw_q) - qm;
    assign rem_fix = (rem >= MODV) ? rem - MODV : rem;
    assign done    = busy;
    assign set_idx = SET_W'(rem_fix);
  end

endmodule

// ----- design/sac_tag_ram.sv -----
// Row-wide tag/stamp memory, one row per set, one write and one read port.
// Read data registered. No package dependency.
module sac_tag_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 520,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/sac_way_sel.sv -----
// Way search and LRU victim pick for one set row, plus the updated row.
// Depends on sac_pkg. Victim found by a min tree over the way stamps.
module sac_way_sel #(
  parameter int MAX_WAYS = sac_pkg::DEF_MAX_WAYS,
  parameter int STAMP_W  = sac_pkg::DEF_STAMP_WIDTH,
  parameter int WAY_W    = 3,
  parameter int LINE_W   = 65
) (
  input  logic [MAX_WAYS*LINE_W-1:0] row,
  input  logic [sac_pkg::TAG_W-1:0]  tag,
  input  logic [MAX_WAYS-1:0]        way_en,
  input  logic [STAMP_W-1:0]         stamp,
  output logic                       hit,
  output logic [WAY_W-1:0]           way,
  output logic [MAX_WAYS*LINE_W-1:0] row_new
);
  import sac_pkg::*;

  localparam int P = 1 << WAY_W;

  logic [MAX_WAYS-1:0] line_vld;
  logic [TAG_W-1:0]    line_tag [MAX_WAYS];
  logic [STAMP_W-1:0]  line_st  [MAX_WAYS];
  logic [MAX_WAYS-1:0] match;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    victim;

  logic [STAMP_W-1:0]  node_st  [WAY_W+1][P];
  logic [WAY_W-1:0]    node_way [WAY_W+1][P];
  logic                node_en  [WAY_W+1][P];

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      line_vld[w] = row[w*LINE_W + LINE_W - 1];
      line_tag[w] = row[w*LINE_W + STAMP_W +: TAG_W];
      line_st[w]  = row[w*LINE_W +: STAMP_W];
      match[w]    = way_en[w] && line_vld[w] && (line_tag[w] == tag);
    end
  end

  // lowest matching way wins
  always_comb begin
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end
  end

  // min tree, ties keep the lower way
  always_comb begin
    for (int l = 0; l <= WAY_W; l++) begin
      for (int i = 0; i < P; i++) begin
        node_st[l][i]  = '0;
        node_way[l][i] = '0;
        node_en[l][i]  = 1'b0;
      end
    end
    for (int i = 0; i < P; i++) begin
      if (i < MAX_WAYS) begin
        node_st[0][i]  = line_st[i];
        node_way[0][i] = WAY_W'(i);
        node_en[0][i]  = way_en[i];
      end
    end
    for (int l = 0; l < WAY_W; l++) begin
      for (int i = 0; i < (P >> (l + 1)); i++) begin
        if (node_en[l][2*i+1] &&
            (!node_en[l][2*i] || (node_st[l][2*i+1] < node_st[l][2*i]))) begin
          node_st[l+1][i]  = node_st[l][2*i+1];
          node_way[l+1][i] = node_way[l][2*i+1];
          node_en[l+1][i]  = 1'b1;
        end else begin
          node_st[l+1][i]  = node_st[l][2*i];
          node_way[l+1][i] = node_way[l][2*i];
          node_en[l+1][i]  = node_en[l][2*i];
        end
      end
    end
  end

  // only a stamp older than the current one displaces way 0
  assign victim = (node_en[WAY_W][0] && (node_st[WAY_W][0] < stamp)) ?
                  node_way[WAY_W][0] : '0;

  assign hit = |match;
  assign way = hit ? hit_way : victim;

  always_comb begin
    row_new = row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == way) begin
        row_new[w*LINE_W +: LINE_W] = {1'b1, tag, stamp};
      end
    end
  end

endmodule

// ----- tb/tb_set_assoc_cache_lru_lookup_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative LRU tag store top level.
// Depends on sac_pkg and set_assoc_cache_lru_lookup_top; predicts each result in-line.
module tb_set_assoc_cache_lru_lookup_top;
  import sac_pkg::*;

  // Storage geometry matches the block's default parameters.
  localparam int MAX_SETS   = DEF_MAX_SETS;
  localparam int MAX_WAYS   = DEF_MAX_WAYS;
  localparam int STAMP_W    = DEF_STAMP_WIDTH;
  localparam int LINE_COUNT = MAX_SETS * MAX_WAYS;

  // Pad after each drain, before config writes and at the end.
  localparam int LATENCY_PAUSE  = 6;
  // Slowest legal quiet stretch is the clearing pass after reset or the forced receiver
  // hold-off; this is several times either.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
  } lookup_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [ADDR_W-1:0]     address;
  logic                  out_valid;
  logic                  out_stall;
  logic                  hit;
  logic [WAY_OUT_W-1:0]  way;
  logic [CNT_W-1:0]      hit_count;
  logic [CNT_W-1:0]      miss_count;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  set_assoc_cache_lru_lookup_top #(
    .MAX_SETS    (MAX_SETS),
    .MAX_WAYS    (MAX_WAYS),
    .STAMP_WIDTH (STAMP_W)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .address    (address),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .way        (way),
    .hit_count  (hit_count),
    .miss_count (miss_count),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow tag store: our own copy of the cache state and the config registers
  // ---------------------------------------------------------------------------
  logic               shadow_valid [LINE_COUNT];
  logic [TAG_W-1:0]   shadow_tag   [LINE_COUNT];
  logic [STAMP_W-1:0] shadow_stamp [LINE_COUNT];
  logic [STAMP_W-1:0] stamp_clock;
  logic [CNT_W-1:0]   hits_seen;
  logic [CNT_W-1:0]   misses_seen;
  logic [CFG_W-1:0]   cfg_offset_bits;
  logic [CFG_W-1:0]   cfg_index_bits;
  logic [CFG_W-1:0]   cfg_ways;

  lookup_result_t pending_lookups[$];  // predicted results, oldest first

  int          failures;
  int          reported;
  bit          no_idle;        // both sides run back to back while set
  int          hold_off_req;   // receiver picks this up and stalls that many cycles
  logic [31:0] tag_base;       // base of the small tag pool used by the random traffic

  // Effective associativity: zero acts as one, above MAX_WAYS is clipped.
  function automatic int unsigned eff_ways();
    int unsigned n;
    n = cfg_ways;
    if (n == 0) n = 1;
    if (n > MAX_WAYS) n = MAX_WAYS;
    return n;
  endfunction

  // One access against the shadow store; updates it and returns the expected word.
  function automatic lookup_result_t lookup_and_update(input logic [ADDR_W-1:0] a);
    int unsigned    ob, ib, nways, shift, set_idx, base, w, chosen;
    logic [31:0]    set_field;
    logic [TAG_W-1:0] tag;
    logic [STAMP_W-1:0] oldest;
    logic           found;
    lookup_result_t r;
    ob    = cfg_offset_bits;
    ib    = cfg_index_bits;
    nways = eff_ways();
    shift = ob + ib;
    // stamp clock saturates rather than wrapping
    if (stamp_clock != '1) stamp_clock = stamp_clock + 1'b1;
    set_field = (a >> ob) & ((32'd1 << ib) - 32'd1);
    set_idx   = set_field % MAX_SETS;   // index wider than storage aliases
    tag       = (shift >= 32) ? '0 : TAG_W'(a >> shift);
    base      = set_idx * MAX_WAYS;
    found     = 1'b0;
    chosen    = 0;
    for (w = 0; w < nways; w++) begin
      if (!found && shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
        found  = 1'b1;
        chosen = w;
      end
    end
    if (found) begin
      shadow_stamp[base + chosen] = stamp_clock;
      if (hits_seen != '1) hits_seen = hits_seen + 1'b1;
    end else begin
      // oldest stamp wins; unused ways hold 0, ties keep the lowest way
      oldest = stamp_clock;
      for (w = 0; w < nways; w++) begin
        if (shadow_stamp[base + w] < oldest) begin
          oldest = shadow_stamp[base + w];
          chosen = w;
        end
      end
      shadow_valid[base + chosen] = 1'b1;
      shadow_tag[base + chosen]   = tag;
      shadow_stamp[base + chosen] = stamp_clock;
      if (misses_seen != '1) misses_seen = misses_seen + 1'b1;
    end
    r.hit        = found;
    r.way        = WAY_OUT_W'(chosen);
    r.hit_count  = hits_seen;
    r.miss_count = misses_seen;
    return r;
  endfunction

  // Random address: mostly a small pool of tags over a few sets so that hits,
  // fills and LRU evictions all happen; the rest is raw noise.
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned ob, ib, shift;
    logic [31:0] set_field, tag, off_mask;
    ob    = cfg_offset_bits;
    ib    = cfg_index_bits;
    shift = ob + ib;
    if ($urandom_range(0, 9) < 3) return $urandom;
    // upper index bits vary so that sets beyond storage alias onto the same rows
    set_field = ($urandom_range(0, 3) + 32'd1024 * $urandom_range(0, 31)) &
                ((32'd1 << ib) - 32'd1);
    tag      = tag_base + $urandom_range(0, eff_ways() + 1);
    off_mask = (32'd1 << ob) - 32'd1;
    return (tag << shift) | (set_field << ob) | ($urandom & off_mask);
  endfunction

  task automatic report_mismatch(input string msg);
    failures++;
    if (reported < REPORT_LIMIT) begin
      reported++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Address channel: one word per call, with a random gap in front
  // ---------------------------------------------------------------------------
  task automatic send_address(input logic [ADDR_W-1:0] a);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    address  <= a;
    do @(posedge clk); while (in_stall);
    // accepted at this edge; valid stays up in case the next word follows at once
    pending_lookups.push_back(lookup_and_update(a));
  endtask

  task automatic send_batch(input int count);
    repeat (count) send_address(pick_address());
  endtask

  // Drop valid, let every predicted word come back, then let the pipe settle.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_lookups.size() > 0) @(posedge clk);
    repeat (LATENCY_PAUSE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Config port
  // ---------------------------------------------------------------------------
  task automatic write_register(input logic [1:0] reg_idx, input logic [CFG_W-1:0] value);
    logic [APB_DATA_W-1:0] wdata;
    wdata = $urandom;
    wdata[CFG_W-1:0] = value;   // upper bits are junk, the block keeps four
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({reg_idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (reg_idx)
      REG_OFFSET_BITS: cfg_offset_bits = value;
      REG_INDEX_BITS:  cfg_index_bits  = value;
      REG_WAYS_IN_USE: cfg_ways        = value;
      default: ;
    endcase
  endtask

  task automatic check_register(input logic [1:0] reg_idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'({reg_idx, 2'b00});
    pwdata  <= $urandom;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(value))
      report_mismatch($sformatf("reg %0d read exp %h got %h", reg_idx, value, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure_cache(input logic [CFG_W-1:0] ob, input logic [CFG_W-1:0] ib,
                                 input logic [CFG_W-1:0] nw);
    write_register(REG_OFFSET_BITS, ob);
    write_register(REG_INDEX_BITS, ib);
    write_register(REG_WAYS_IN_USE, nw);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: 64-byte blocks, 16 sets, direct mapped.
  task automatic test_reset_config();
    send_address(32'h0000_0000);
    send_address(32'h0000_0000);   // same block: hit
    send_address(32'h0000_003F);   // last byte of that block: hit
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0400);   // set 0, new tag: evicts
    send_address(32'h0000_0000);
    wait_drain();
  endtask

  // Eight ways in one set: fill in order, refresh one, then evict the oldest.
  task automatic test_lru_order();
    configure_cache(4'd0, 4'd0, 4'd8);
    for (int k = 1; k <= 8; k++) send_address(ADDR_W'(k));
    send_address(32'd1);
    send_address(32'd9);
    send_address(32'd2);
    wait_drain();
  endtask

  // Way count of zero and above MAX_WAYS, widest bit counts with aliased sets.
  task automatic test_config_limits();
    configure_cache(4'd0, 4'd0, 4'd0);
    send_address(32'd3);
    send_address(32'd4);
    wait_drain();
    configure_cache(4'd0, 4'd0, 4'd15);
    send_address(32'd5);
    send_address(32'd3);
    wait_drain();
    configure_cache(4'd15, 4'd15, 4'd8);
    check_register(REG_OFFSET_BITS, 4'd15);
    check_register(REG_INDEX_BITS, 4'd15);
    check_register(REG_WAYS_IN_USE, 4'd8);
    send_address(32'hFFFF_FFFF);
    send_address(32'hC1FF_8000);   // index differs only above storage: same row, hit
    send_address(32'h0000_7FFF);
    wait_drain();
    configure_cache(4'd0, 4'd15, 4'd2);
    send_address(32'h0000_7FFF);
    wait_drain();
  endtask

  // Phases of random traffic, each with its own register setting.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] ob, ib, nw;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin ob = 4'd0;  ib = 4'd0;  nw = 4'd8;  end
        1: begin ob = 4'd12; ib = 4'd10; nw = 4'd8;  end
        2: begin ob = 4'd15; ib = 4'd15; nw = 4'd15; end
        3: begin ob = 4'd6;  ib = 4'd4;  nw = 4'd1;  end
        4: begin ob = 4'd0;  ib = 4'd3;  nw = 4'd0;  end
        5: begin ob = 4'd4;  ib = 4'd2;  nw = 4'd4;  end
        default: begin
          ob = CFG_W'($urandom_range(0, 15));
          ib = CFG_W'($urandom_range(0, 6));
          nw = CFG_W'($urandom_range(0, 15));
        end
      endcase
      configure_cache(ob, ib, nw);
      tag_base = (phase == 0) ? 32'hFFFF_FFF4 : $urandom;
      no_idle  = (phase % 3 == 2);
      send_batch(55);
      wait_drain();
    end
    no_idle = 1'b0;
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // block fills up and must stall its input.
  task automatic test_backpressure();
    configure_cache(4'd2, 4'd1, 4'd3);
    tag_base     = $urandom;
    no_idle      = 1'b1;
    hold_off_req = HOLD_OFF_CYCLES;
    send_batch(50);
    no_idle = 1'b0;
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each accepted word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("unexpected word hit=%0d way=%0d hits=%h misses=%h",
                                  hit, way, hit_count, miss_count));
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit || way !== want.way ||
            hit_count !== want.hit_count || miss_count !== want.miss_count)
          report_mismatch($sformatf(
            "exp hit=%0d way=%0d hits=%h misses=%h, got hit=%0d way=%0d hits=%h misses=%h",
            want.hit, want.way, want.hit_count, want.miss_count,
            hit, way, hit_count, miss_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall after each word, plus the forced hold-off
  // ---------------------------------------------------------------------------
  int stall_left;
  int hold_left;

  always @(posedge clk) begin
    bit took;
    took = out_valid && !out_stall;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (took) stall_left = no_idle ? 0 : $urandom_range(0, 7);
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too many cycles without any handshake ends the run
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    address  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    failures     = 0;
    reported     = 0;
    no_idle      = 1'b0;
    hold_off_req = 0;
    tag_base     = '0;
    for (int i = 0; i < LINE_COUNT; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i]   = '0;
      shadow_stamp[i] = '0;
    end
    stamp_clock     = '0;
    hits_seen       = '0;
    misses_seen     = '0;
    cfg_offset_bits = RST_OFFSET_BITS;
    cfg_index_bits  = RST_INDEX_BITS;
    cfg_ways        = RST_WAYS_IN_USE;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // the block runs its clearing pass now with in_stall high; send_address waits it out
    test_reset_config();
    test_lru_order();
    test_config_limits();
    test_random_traffic();
    test_backpressure();

    wait_drain();
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
